// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define CDST_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// clocked assertion that also holds through reset
`define CDST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/cdst_pkg.sv
// shared types and constants of the sharer tracking directory
`default_nettype none
package cdst_pkg;

    localparam int OP_W       = 3;
    localparam int SET_W      = 8;
    localparam int WAY_W      = 3;
    localparam int SUB_W      = 2;
    localparam int NODE_W     = 7;
    localparam int NODE_IDX_W = 6;
    localparam int COUNT_W    = 7;

    localparam int REQ_W      = 23;
    localparam int RESULT_W   = 17;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;

    localparam logic [OP_W-1:0] OP_SET_OWNER     = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_SHARER    = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_SHARER = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR_SHARERS = 3'd3;
    localparam logic [OP_W-1:0] OP_TEST_SHARER   = 3'd4;
    localparam logic [OP_W-1:0] OP_GROUP_QUERY   = 3'd5;

    localparam logic signed [NODE_W-1:0] NODE_NONE = -7'sd1;

    // request as packed on s_tdata, opcode in the lowest bits
    typedef struct packed {
        logic signed [NODE_W-1:0] node;
        logic [SUB_W-1:0]         sub_index;
        logic [WAY_W-1:0]         way_index;
        logic [SET_W-1:0]         set_index;
        logic [OP_W-1:0]          opcode;
    } request_t;

    // result as packed on m_tdata, is_sharer in the lowest bit
    typedef struct packed {
        logic                     error;
        logic [COUNT_W-1:0]       sharer_count;
        logic signed [NODE_W-1:0] owner;
        logic                     group_busy;
        logic                     is_sharer;
    } result_t;

endpackage
`default_nettype wire

// File: rtl/cdst_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none
module cdst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    aclk,
    wr_en,
    wr_addr,
    wr_data,
    rd_en,
    rd_addr,
    rd_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  wire logic             aclk;
    input  wire logic             wr_en;
    input  wire logic [AW-1:0]    wr_addr;
    input  wire logic [WIDTH-1:0] wr_data;
    input  wire logic             rd_en;
    input  wire logic [AW-1:0]    rd_addr;
    output logic      [WIDTH-1:0] rd_data;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: rtl/cdst_fifo.sv
// short register queue between the request front end and the directory back end
`default_nettype none
module cdst_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  full,
    output logic                  empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// File: rtl/cdst_front.sv
// request front end: takes requests, folds the coordinates, checks the node
`default_nettype none
module cdst_front #(
    parameter int SETS      = 256,
    parameter int WAYS      = 8,
    parameter int SUBBLOCKS = 4,
    parameter int NODES     = 16,
    parameter int ROW_AW    = 11,
    parameter int SUB_IW    = 2,
    parameter int ITEM_W    = 25
) (
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [cdst_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                        clear_done,
    input  wire logic                        q_full,
    output logic                             q_push,
    output logic      [ITEM_W-1:0]           q_data
);
    import cdst_pkg::*;

    localparam int SET_IW = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_IW = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef struct packed {
        logic                     err;
        logic                     node_ok;
        logic signed [NODE_W-1:0] node;
        logic [SUB_IW-1:0]        sub;
        logic [ROW_AW-1:0]        row;
        logic [OP_W-1:0]          op;
    } item_t;

    request_t          req;
    item_t             item;
    logic [SET_IW-1:0] set_tab [2**SET_W];
    logic [WAY_IW-1:0] way_tab [2**WAY_W];
    logic [SUB_IW-1:0] sub_tab [2**SUB_W];
    logic [SET_IW-1:0] set_red;
    logic [WAY_IW-1:0] way_red;
    logic              node_ok;
    logic              owner_ok;

    // constant folding tables for coordinates beyond the directory size
    for (genvar i = 0; i < 2**SET_W; i++) begin : g_set_tab
        assign set_tab[i] = SET_IW'(i % SETS);
    end
    for (genvar i = 0; i < 2**WAY_W; i++) begin : g_way_tab
        assign way_tab[i] = WAY_IW'(i % WAYS);
    end
    for (genvar i = 0; i < 2**SUB_W; i++) begin : g_sub_tab
        assign sub_tab[i] = SUB_IW'(i % SUBBLOCKS);
    end

    assign req     = request_t'(s_tdata[REQ_W-1:0]);
    assign set_red = set_tab[req.set_index];
    assign way_red = way_tab[req.way_index];

    assign node_ok  = !req.node[NODE_W-1]
                      && ({1'b0, req.node[NODE_IDX_W-1:0]} < NODE_W'(NODES));
    assign owner_ok = node_ok || (req.node == NODE_NONE);

    always_comb begin
        item.op      = req.opcode;
        item.row     = ROW_AW'(ROW_AW'(set_red) * ROW_AW'(WAYS) + ROW_AW'(way_red));
        item.sub     = sub_tab[req.sub_index];
        item.node    = req.node;
        item.node_ok = node_ok;
        item.err     = 1'b0;
        if (req.opcode == OP_SET_OWNER) begin
            item.err = !owner_ok;
        end else if (req.opcode inside {OP_ADD_SHARER, OP_REMOVE_SHARER, OP_TEST_SHARER}) begin
            item.err = !node_ok;
        end
    end

    assign s_tready = clear_done && !q_full;
    assign q_push   = s_tvalid && s_tready;
    assign q_data   = item;

endmodule
`default_nettype wire

// File: rtl/cdst_back.sv
// directory back end: reset clear sweep, row read, entry update and write back, result register
`default_nettype none
module cdst_back #(
    parameter int SUBBLOCKS = 4,
    parameter int NODES     = 16,
    parameter int ROWS      = 2048,
    parameter int ROW_AW    = 11,
    parameter int SUB_IW    = 2,
    parameter int ITEM_W    = 25
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        q_empty,
    output logic                             q_pop,
    input  wire logic [ITEM_W-1:0]           q_data,
    output logic                             clear_done,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [cdst_pkg::M_TDATA_W-1:0] m_tdata
);
    import cdst_pkg::*;

    localparam int CNT_W = $clog2(NODES + 1);
    localparam int ENT_W = NODE_W + CNT_W + NODES;
    localparam int ROW_W = SUBBLOCKS * ENT_W;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    typedef struct packed {
        logic                     err;
        logic                     node_ok;
        logic signed [NODE_W-1:0] node;
        logic [SUB_IW-1:0]        sub;
        logic [ROW_AW-1:0]        row;
        logic [OP_W-1:0]          op;
    } item_t;

    typedef struct packed {
        logic signed [NODE_W-1:0] owner;
        logic [CNT_W-1:0]         count;
        logic [NODES-1:0]         vec;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{owner: NODE_NONE, count: '0, vec: '0};

    logic [1:0]        state_reg, state_next;
    logic [ROW_AW-1:0] clr_addr_reg, clr_addr_next;
    item_t             cur_reg, cur_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_data_reg, out_data_next;

    item_t             q_item;
    logic              ram_we;
    logic [ROW_AW-1:0] ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [ROW_W-1:0]  rd_row;
    logic [ROW_W-1:0]  new_row;
    logic [ROW_W-1:0]  clear_row;
    entry_t            row_ents [SUBBLOCKS];
    logic [SUBBLOCKS-1:0] ent_busy;
    entry_t            cur_entry;
    entry_t            new_entry;
    logic [NODES-1:0]  mask;
    logic              present;
    logic              out_free;
    result_t           result;

    assign q_item    = item_t'(q_data);
    assign clear_row = {SUBBLOCKS{ENTRY_RESET}};

    cdst_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (q_item.row),
        .rd_data (rd_row)
    );

    // split the row into its sub-block entries and put the updated one back
    for (genvar k = 0; k < SUBBLOCKS; k++) begin : g_ent
        assign row_ents[k] = entry_t'(rd_row[k*ENT_W +: ENT_W]);
        assign ent_busy[k] = (row_ents[k].count != '0) || !row_ents[k].owner[NODE_W-1];
        assign new_row[k*ENT_W +: ENT_W] =
            (cur_reg.sub == SUB_IW'(k)) ? new_entry : row_ents[k];
    end

    assign cur_entry = row_ents[cur_reg.sub];
    assign mask      = cur_reg.node_ok ? (NODES'(1) << cur_reg.node[NODE_IDX_W-1:0]) : '0;
    assign present   = |(cur_entry.vec & mask);

    always_comb begin
        new_entry = cur_entry;
        case (cur_reg.op)
            OP_SET_OWNER: begin
                if (!cur_reg.err) begin
                    new_entry.owner = cur_reg.node;
                end
            end
            OP_ADD_SHARER: begin
                if (!cur_reg.err && !present) begin
                    new_entry.vec   = cur_entry.vec | mask;
                    new_entry.count = cur_entry.count + CNT_W'(1);
                end
            end
            OP_REMOVE_SHARER: begin
                if (!cur_reg.err && present) begin
                    new_entry.vec   = cur_entry.vec & ~mask;
                    new_entry.count = cur_entry.count - CNT_W'(1);
                end
            end
            OP_CLEAR_SHARERS: begin
                new_entry.vec   = '0;
                new_entry.count = '0;
            end
            default: begin
                new_entry = cur_entry;
            end
        endcase
    end

    always_comb begin
        result.is_sharer    = (cur_reg.op != OP_GROUP_QUERY) && |(new_entry.vec & mask);
        result.group_busy   = (cur_reg.op == OP_GROUP_QUERY) && |ent_busy;
        result.owner        = new_entry.owner;
        result.sharer_count = COUNT_W'(new_entry.count);
        result.error        = cur_reg.err;
    end

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_reg.row;
        ram_wdata      = new_row;
        ram_re         = 1'b0;
        q_pop          = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = clear_row;
                if (clr_addr_reg == ROW_AW'(ROWS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + ROW_AW'(1);
                end
            end
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    ram_re     = 1'b1;
                    cur_next   = q_item;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // read data holds while the result register is still full
                if (out_free) begin
                    ram_we         = 1'b1;
                    out_valid_next = 1'b1;
                    out_data_next  = result;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
    end

    assign clear_done = (state_reg != ST_CLEAR);
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = M_TDATA_W'(out_data_reg);

endmodule
`default_nettype wire

// File: rtl/coherence_directory_sharer_tracker.sv
// top level of the full bit vector sharer tracking directory
//
//  channel | dir | handshake           | payload
//  s_      | in  | s_tvalid / s_tready | opcode, set_index, way_index, sub_index, node
//  m_      | out | m_tvalid / m_tready | is_sharer, group_busy, owner, sharer_count, error
//
// in the back end each request takes a row read from the single
// read port of the directory ram, then the entry update and its write back.
// after reset the ram is swept one row a cycle, all SETS*WAYS rows (2048 by
// default), with s_tready low; requests queue in two slots ahead of the
// back end, and a full result register stalls the back end in its write cycle.
`default_nettype none
module coherence_directory_sharer_tracker #(
    parameter int SETS      = 256,
    parameter int WAYS      = 8,
    parameter int SUBBLOCKS = 4,
    parameter int NODES     = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // opcode, set_index, way_index, sub_index, node
    input  wire logic [cdst_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // is_sharer, group_busy, owner, sharer_count, error
    output logic      [cdst_pkg::M_TDATA_W-1:0] m_tdata
);
    import cdst_pkg::*;

    localparam int ROWS   = SETS * WAYS;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SUB_IW = (SUBBLOCKS > 1) ? $clog2(SUBBLOCKS) : 1;
    localparam int ITEM_W = 2 + NODE_W + SUB_IW + ROW_AW + OP_W;

    logic              clear_done;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    logic [ITEM_W-1:0] q_wdata;
    logic [ITEM_W-1:0] q_rdata;

    cdst_front #(
        .SETS      (SETS),
        .WAYS      (WAYS),
        .SUBBLOCKS (SUBBLOCKS),
        .NODES     (NODES),
        .ROW_AW    (ROW_AW),
        .SUB_IW    (SUB_IW),
        .ITEM_W    (ITEM_W)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .clear_done (clear_done),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    cdst_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (2)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .full      (q_full),
        .empty     (q_empty)
    );

    cdst_back #(
        .SUBBLOCKS (SUBBLOCKS),
        .NODES     (NODES),
        .ROWS      (ROWS),
        .ROW_AW    (ROW_AW),
        .SUB_IW    (SUB_IW),
        .ITEM_W    (ITEM_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_data     (q_rdata),
        .clear_done (clear_done),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
`default_nettype wire

// File: rtl/cdst_checker.sv
// port level checks of the sharer tracking directory, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module cdst_checker #(
    parameter int NODES = 16
) (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [cdst_pkg::M_TDATA_W-1:0] m_tdata
);
    import cdst_pkg::*;

    result_t res;

    assign res = result_t'(m_tdata[RESULT_W-1:0]);

    `CDST_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_tvalid && !s_tready, "ports not quiet after reset")
    `CDST_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
    `CDST_ASSERT(a_pad_zero, aclk, aresetn, m_tvalid |-> m_tdata[M_TDATA_W-1:RESULT_W] == '0, "tdata padding not zero")
    `CDST_ASSERT(a_count_range, aclk, aresetn, m_tvalid |-> res.sharer_count <= COUNT_W'(NODES), "sharer count above node count")
    `CDST_ASSERT(a_query_excl, aclk, aresetn, m_tvalid |-> !(res.is_sharer && res.group_busy), "sharer bit reported on group query")

endmodule

bind coherence_directory_sharer_tracker cdst_checker #(
    .NODES (NODES)
) u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
